@@ src/lkc_pkg.sv @@
// Shared constants, types and helpers for the LRU key cache.
// Used by every module under src; depends on nothing else.
package lkc_pkg;

  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 64;

  localparam int CAP_W     = 5;
  localparam int SLOT_W    = 4;
  localparam int OCC_W     = 5;
  localparam int CNT_W32   = 32;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 1;

  localparam logic [CAP_W-1:0]  CAP_RESET     = 5'd16;
  localparam logic [APB_AW-1:0] ADDR_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } lkc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming key
    logic search;  // compare and resolve hit, victim and free slot
    logic commit;  // update stores and publish the result
  } lkc_cmd_t;

  function automatic logic [CNT_W32-1:0] sat_inc32(input logic [CNT_W32-1:0] x);
    sat_inc32 = (x == '1) ? x : x + 32'd1;
  endfunction

endpackage

@@ src/lru_key_cache.sv @@
// Top level of the LRU key cache: APB register block, controller, datapath.
// Depends on lkc_pkg, lkc_regs, lkc_ctrl and lkc_datapath.
//
// Fully associative cache of keys with least-recently-used replacement.
// An item is taken when start is high and busy is low; it then goes through
// search (all entries compare the key at once, and the hit, the oldest entry and
// the lowest free slot are resolved) and then commit (ranks, stores and counters
// update). A new item may be started in the commit cycle, so a new item can be
// taken while the last one is still in commit. The result is on the result ports
// with done high for exactly one cycle, registered from the commit state. The
// result registers hold it only until the next commit, so capture it when done
// is high. Reset clears every valid bit at once: no warm-up sweep is needed.
// Write capacity only while no item is in flight.
module lru_key_cache
  import lkc_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic [KEY_BITS-1:0] lookup_key,
  output logic                done,
  output logic                hit,
  output logic [SLOT_W-1:0]   slot,
  output logic [CNT_W32-1:0]  entry_id,
  output logic [CNT_W32-1:0]  visit_count,
  output logic                evicted,
  output logic [KEY_BITS-1:0] evicted_key,
  output logic [OCC_W-1:0]    occupancy,
  output logic [CNT_W32-1:0]  total_lookups,
  output logic [CNT_W32-1:0]  total_hits
);

  logic [CAP_W-1:0] capacity;
  lkc_cmd_t         cmd;

  lkc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lkc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lkc_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .capacity      (capacity),
    .lookup_key    (lookup_key),
    .done          (done),
    .hit           (hit),
    .slot          (slot),
    .entry_id      (entry_id),
    .visit_count   (visit_count),
    .evicted       (evicted),
    .evicted_key   (evicted_key),
    .occupancy     (occupancy),
    .total_lookups (total_lookups),
    .total_hits    (total_hits)
  );

  // Every accepted item produces its result with done high.
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted item produced no result");

  // Busy covers only the search state and is never held beyond it.
  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held beyond the search cycle");

  // A hit never evicts, and a result without eviction reports a zero key.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && (hit || !evicted)) |-> (!evicted || !hit) && (evicted || evicted_key == '0))
    else $error("eviction reported inconsistently");

endmodule

@@ src/lkc_regs.sv @@
// APB configuration register block: holds the capacity register.
// Depends on lkc_pkg.
module lkc_regs
  import lkc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CAP_W-1:0]  capacity
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_en) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CAPACITY) begin
      prdata = {{(APB_DW-CAP_W){1'b0}}, capacity};
    end
  end

endmodule

@@ src/lkc_ctrl.sv @@
// Controller for the LRU key cache: sequences accept, search and commit.
// Depends on lkc_pkg.
module lkc_ctrl
  import lkc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output lkc_cmd_t  cmd
);

  lkc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
        if (start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        busy       = 1'b1;
        cmd.search = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The stores settle at this edge, so a new item may enter now.
        cmd.commit = 1'b1;
        cmd.load   = start;
        state_next = start ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/lkc_datapath.sv @@
// Datapath of the LRU key cache: entry stores, parallel key compare,
// recency ranks, counters and result registers. Depends on lkc_pkg.
module lkc_datapath
  import lkc_pkg::*;
#(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  lkc_cmd_t            cmd,
  input  logic [CAP_W-1:0]    capacity,
  input  logic [KEY_BITS-1:0] lookup_key,
  output logic                done,
  output logic                hit,
  output logic [SLOT_W-1:0]   slot,
  output logic [CNT_W32-1:0]  entry_id,
  output logic [CNT_W32-1:0]  visit_count,
  output logic                evicted,
  output logic [KEY_BITS-1:0] evicted_key,
  output logic [OCC_W-1:0]    occupancy,
  output logic [CNT_W32-1:0]  total_lookups,
  output logic [CNT_W32-1:0]  total_hits
);

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  // Entry stores
  logic                valid     [ENTRIES];
  logic [IW-1:0]       rank      [ENTRIES];
  logic [KEY_BITS-1:0] keys      [ENTRIES];
  logic [CNT_W32-1:0]  ids       [ENTRIES];
  logic [CNT_W32-1:0]  visits    [ENTRIES];

  logic [KEY_BITS-1:0] key_q;
  logic [CNT_W-1:0]    valid_count;
  logic [CNT_W32-1:0]  lookup_cnt;
  logic [CNT_W32-1:0]  hit_cnt;
  logic [CNT_W32-1:0]  next_id;

  // Search results
  logic                hit_s;
  logic                evict_s;
  logic [IW-1:0]       found_s;
  logic [IW-1:0]       victim_s;
  logic [IW-1:0]       ins_s;
  logic [IW-1:0]       rank_f_s;
  logic [CNT_W32-1:0]  id_f_s;
  logic [CNT_W32-1:0]  visit_f_s;
  logic [KEY_BITS-1:0] ev_key_s;

  // Search-stage logic
  logic          any_match;
  logic          any_free;
  logic [IW-1:0] found_c;
  logic [IW-1:0] victim_c;
  logic [IW-1:0] free_c;
  logic [IW-1:0] ins_c;
  logic [IW-1:0] lru_rank;
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] eff_cap;
  logic          evict_c;

  assign cap_ext  = CW'(capacity);
  assign lru_rank = IW'(valid_count - CNT_W'(1));

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Lowest index wins: scan downward so the last assignment is the lowest.
  always_comb begin
    any_match = 1'b0;
    any_free  = 1'b0;
    found_c   = '0;
    victim_c  = '0;
    free_c    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key_q) begin
        any_match = 1'b1;
        found_c   = IW'(i);
      end
      if (!valid[i]) begin
        any_free = 1'b1;
        free_c   = IW'(i);
      end
      // Valid ranks are distinct and dense, so the oldest holds count - 1.
      if (valid[i] && rank[i] == lru_rank) begin
        victim_c = IW'(i);
      end
    end
  end

  assign evict_c = !any_match && (CW'(valid_count) >= eff_cap);

  always_comb begin
    if (evict_c && !(any_free && free_c < victim_c)) begin
      ins_c = victim_c;
    end else begin
      ins_c = free_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= lookup_key;
    end
    if (cmd.search) begin
      hit_s     <= any_match;
      evict_s   <= evict_c;
      found_s   <= found_c;
      victim_s  <= victim_c;
      ins_s     <= ins_c;
      rank_f_s  <= rank[found_c];
      id_f_s    <= ids[found_c];
      visit_f_s <= visits[found_c];
      ev_key_s  <= keys[victim_c];
    end
  end

  // Commit-stage logic
  logic [IW-1:0]          slot_c;
  logic [IW+SLOT_W-1:0]   slot_wide;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign slot_c    = hit_s ? found_s : ins_s;
  assign slot_wide = {{SLOT_W{1'b0}}, slot_c};
  assign occ_wide  = {{OCC_W{1'b0}}, count_next};

  always_comb begin
    count_next = valid_count;
    if (!hit_s && !evict_s) begin
      count_next = valid_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        rank[i]  <= '0;
      end
      valid_count <= '0;
      lookup_cnt  <= '0;
      hit_cnt     <= '0;
      next_id     <= '0;
    end else if (cmd.commit) begin
      lookup_cnt  <= sat_inc32(lookup_cnt);
      valid_count <= count_next;
      if (hit_s) begin
        hit_cnt <= sat_inc32(hit_cnt);
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && rank[i] < rank_f_s) rank[i] <= rank[i] + IW'(1);
        end
        rank[found_s] <= '0;
      end else begin
        next_id <= next_id + 32'd1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && !(evict_s && IW'(i) == victim_s)) rank[i] <= rank[i] + IW'(1);
        end
        // The victim slot stays valid when the new key lands in it.
        if (evict_s && victim_s != ins_s) valid[victim_s] <= 1'b0;
        valid[ins_s] <= 1'b1;
        rank[ins_s]  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit_s) begin
        visits[found_s] <= sat_inc32(visit_f_s);
      end else begin
        keys[ins_s]   <= key_q;
        ids[ins_s]    <= next_id;
        visits[ins_s] <= '0;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit           <= hit_s;
      slot          <= slot_wide[SLOT_W-1:0];
      entry_id      <= hit_s ? id_f_s : next_id;
      visit_count   <= hit_s ? sat_inc32(visit_f_s) : '0;
      evicted       <= evict_s;
      evicted_key   <= evict_s ? ev_key_s : '0;
      occupancy     <= occ_wide[OCC_W-1:0];
      total_lookups <= sat_inc32(lookup_cnt);
      total_hits    <= hit_s ? sat_inc32(hit_cnt) : hit_cnt;
    end
  end

endmodule
